// ----- rtl/clx_pkg.sv -----
// Shared types, constants and the keyword lookup for the C subset lexer.
// Used by clx_front, clx_queue, clx_back and c_subset_lexer; no dependencies.
package clx_pkg;

  // Sizing
  localparam int MAX_TOKEN_LEN = 64;
  localparam int ROW_BITS      = 16;
  localparam int COL_BITS      = 12;
  localparam int LEN_BITS      = $clog2(MAX_TOKEN_LEN + 1);
  localparam int TOK_LEN_W     = 7;
  localparam int KIND_W        = 3;
  localparam int KW_W          = 4;
  localparam int CHAR_W        = 8;
  localparam int WIN_BYTES     = 6;
  localparam int WIN_BITS      = CHAR_W * WIN_BYTES;
  localparam int NUM_KW        = 10;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Stream payload widths
  localparam int IN_DATA_W   = CHAR_W;
  localparam int OUT_FIELD_W = KIND_W + KW_W + ROW_BITS + COL_BITS + TOK_LEN_W + 1;
  localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

  // Special characters
  localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_QUOTE = 8'h22;
  localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;
  localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;

  typedef enum logic [KIND_W-1:0] {
    TK_KEYWORD = 3'd0,
    TK_IDENT   = 3'd1,
    TK_NUMBER  = 3'd2,
    TK_OPER    = 3'd3,
    TK_DELIM   = 3'd4,
    TK_END     = 3'd5
  } token_kind_e;

  typedef enum logic [3:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_NUMBER,
    MODE_SLASH,
    MODE_DIRECTIVE,
    MODE_LINE,
    MODE_BLOCK,
    MODE_BLOCK_STAR,
    MODE_STRING
  } lex_mode_e;

  // Keywords, right-aligned in the window: int float char double void if else while for return
  localparam logic [WIN_BITS-1:0] KW_CODE [NUM_KW] = '{
    48'h0000_0069_6E74, 48'h0066_6C6F_6174, 48'h0000_6368_6172, 48'h646F_7562_6C65,
    48'h0000_766F_6964, 48'h0000_0000_6966, 48'h0000_656C_7365, 48'h0077_6869_6C65,
    48'h0000_0066_6F72, 48'h7265_7475_726E
  };
  localparam logic [2:0] KW_LEN [NUM_KW] = '{
    3'd3, 3'd5, 3'd4, 3'd6, 3'd4, 3'd2, 3'd4, 3'd5, 3'd3, 3'd6
  };

  // One token as the front sees it; identifiers are resolved to keywords later
  typedef struct packed {
    token_kind_e          kind;
    logic [WIN_BITS-1:0]  win;
    logic [ROW_BITS-1:0]  row;
    logic [COL_BITS-1:0]  col;
    logic [LEN_BITS-1:0]  len;
    logic                 too;
  } clx_desc_t;

  // All tokens caused by one source byte
  typedef struct packed {
    logic      two;
    clx_desc_t d0;
    clx_desc_t d1;
  } clx_entry_t;

  typedef struct packed {
    logic            hit;
    logic [KW_W-1:0] idx;
  } kw_match_t;

  // Match a word against the keyword list; the first hit wins
  function automatic kw_match_t kw_lookup(logic [WIN_BITS-1:0] win,
                                          logic [LEN_BITS-1:0] len,
                                          logic                too);
    kw_match_t r;
    r = '0;
    for (int i = 0; i < NUM_KW; i++) begin
      if (!r.hit && !too && len == LEN_BITS'(KW_LEN[i]) && win == KW_CODE[i]) begin
        r.hit = 1'b1;
        r.idx = KW_W'(i);
      end
    end
    return r;
  endfunction

endpackage

// ----- rtl/c_subset_lexer.sv -----
// Top level of the C subset lexer: front end, token queue and back end.
// Depends on clx_pkg, clx_front, clx_queue and clx_back.
//
// The lexer takes one source byte per cycle on the input stream while the
// queue has room (tlast marks end of source) and gives one token descriptor
// per cycle on the output stream while the sink is ready. A byte leaves
// through the front in the cycle it is accepted. A byte that closes a pending
// token and is itself a delimiter or an operator other than a slash, and the
// end marker after a pending token, each give two descriptors; these leave
// the single output register one per cycle, so the output side sets the rate
// at one token per cycle while the four-entry queue absorbs the difference
// and lets the input keep streaming. Output tlast marks the last descriptor
// caused by each input request, so the end token always carries it, and after
// the end token all row and column counting starts again from the reset state.
module c_subset_lexer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [clx_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // [7:0] char_byte
  input  logic                           s_axis_tlast,  // end_of_input
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // token_kind, keyword_index, start_row, start_column, token_length,
  // too_long from the lowest bit up, then zero fill
  output logic [clx_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic                           m_axis_tlast   // last_of_run
);
  import clx_pkg::*;

  logic        push;
  clx_entry_t  push_entry;
  logic        pop;
  clx_entry_t  head;
  logic        q_empty;
  logic        q_full;

  clx_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .char_i     (s_axis_tdata),
    .eoi_i      (s_axis_tlast),
    .q_full_i   (q_full),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  clx_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  clx_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (q_empty),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

// ----- rtl/clx_front.sv -----
// Front end of the lexer: takes source bytes, tracks row/column and the
// scan mode, and turns each byte into zero, one or two token descriptors.
// Depends on clx_pkg.
module clx_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            char_i,
  input  logic                  eoi_i,
  input  logic                  q_full_i,
  output logic                  push_o,
  output clx_pkg::clx_entry_t   entry_o
);
  import clx_pkg::*;

  localparam logic [ROW_BITS-1:0] ROW_MAX = '1;
  localparam logic [COL_BITS-1:0] COL_MAX = '1;

  lex_mode_e             mode_q, mode_d;
  logic [WIN_BITS-1:0]   win_q, win_d;
  logic [LEN_BITS-1:0]   len_q, len_d;
  logic [ROW_BITS-1:0]   row_q, row_d;
  logic [COL_BITS-1:0]   col_q, col_d;
  logic [COL_BITS-1:0]   tcol_q, tcol_d;
  logic                  ovf_q, ovf_d;

  logic                  accept;
  logic                  byte_step;
  logic                  is_alpha, is_digit, is_oper, is_delim, is_nl;
  logic                  pend_tok;
  logic                  flush_step;
  logic                  idle_step;
  logic                  idle_tok;
  logic [COL_BITS-1:0]   col_inc;
  logic [COL_BITS-1:0]   col_end;
  clx_desc_t             flush_desc;
  clx_desc_t             idle_desc;
  clx_desc_t             end_desc;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign byte_step  = accept && !eoi_i;

  // Classify the byte
  assign is_alpha = (char_i >= "a" && char_i <= "z") || (char_i >= "A" && char_i <= "Z") ||
                    (char_i == "_");
  assign is_digit = (char_i >= "0" && char_i <= "9");
  assign is_oper  = (char_i == "+") || (char_i == "-") || (char_i == "*") || (char_i == "/") ||
                    (char_i == "=") || (char_i == "<") || (char_i == ">");
  assign is_delim = (char_i == ";") || (char_i == ",") || (char_i == "(") || (char_i == ")") ||
                    (char_i == "{") || (char_i == "}");
  assign is_nl    = (char_i == CH_NL);

  // Column of this byte, and of the end marker
  assign col_inc = (!is_nl && col_q != COL_MAX) ? col_q + COL_BITS'(1) : col_q;
  assign col_end = (col_q != COL_MAX) ? col_q + COL_BITS'(1) : col_q;

  // Decide whether the byte closes a pending token and is then scanned afresh
  always_comb begin
    pend_tok   = (mode_q == MODE_IDENT) || (mode_q == MODE_NUMBER) || (mode_q == MODE_SLASH);
    flush_step = 1'b0;
    if (byte_step) begin
      unique case (mode_q)
        MODE_IDENT:  flush_step = !(is_alpha || is_digit);
        MODE_NUMBER: flush_step = !is_digit;
        MODE_SLASH:  flush_step = (char_i != CH_SLASH) && (char_i != CH_STAR);
        default:     flush_step = 1'b0;
      endcase
    end
    idle_step = byte_step && (flush_step || mode_q == MODE_IDLE);
    idle_tok  = idle_step && char_i != CH_SLASH && (is_oper || is_delim);
  end

  // Next state
  always_comb begin
    mode_d = mode_q;
    win_d  = win_q;
    len_d  = len_q;
    row_d  = row_q;
    col_d  = col_q;
    tcol_d = tcol_q;
    ovf_d  = ovf_q;
    if (accept && eoi_i) begin
      mode_d = MODE_IDLE;
      win_d  = '0;
      len_d  = '0;
      row_d  = ROW_BITS'(1);
      col_d  = '0;
      tcol_d = '0;
      ovf_d  = 1'b0;
    end else if (byte_step) begin
      col_d = col_inc;
      unique case (mode_q)
        MODE_IDENT, MODE_NUMBER: begin
          if (!flush_step) begin
            if (len_q < LEN_BITS'(MAX_TOKEN_LEN)) begin
              if (len_q < LEN_BITS'(WIN_BYTES)) begin
                win_d = {win_q[WIN_BITS-CHAR_W-1:0], char_i};
              end
              len_d = len_q + LEN_BITS'(1);
            end else begin
              ovf_d = 1'b1;
            end
          end
        end
        MODE_SLASH: begin
          if (char_i == CH_SLASH) begin
            mode_d = MODE_LINE;
          end else if (char_i == CH_STAR) begin
            mode_d = MODE_BLOCK;
          end
        end
        MODE_DIRECTIVE, MODE_LINE: begin
          if (is_nl) mode_d = MODE_IDLE;
        end
        MODE_BLOCK: begin
          if (char_i == CH_STAR) mode_d = MODE_BLOCK_STAR;
        end
        MODE_BLOCK_STAR: begin
          if (char_i == CH_SLASH) begin
            mode_d = MODE_IDLE;
          end else if (char_i != CH_STAR) begin
            mode_d = MODE_BLOCK;
          end
        end
        MODE_STRING: begin
          if (char_i == CH_QUOTE) mode_d = MODE_IDLE;
        end
        default: mode_d = MODE_IDLE;
      endcase
      // Drop the pending token once it has been handed on
      if (flush_step) begin
        mode_d = MODE_IDLE;
        win_d  = '0;
        len_d  = '0;
        ovf_d  = 1'b0;
      end
      // Scan the byte from idle
      if (idle_step) begin
        if (char_i == CH_HASH) begin
          mode_d = MODE_DIRECTIVE;
        end else if (char_i == CH_SLASH) begin
          mode_d = MODE_SLASH;
          tcol_d = col_inc;
        end else if (char_i == CH_QUOTE) begin
          mode_d = MODE_STRING;
        end else if (is_alpha || is_digit) begin
          mode_d = is_alpha ? MODE_IDENT : MODE_NUMBER;
          tcol_d = col_inc;
          len_d  = LEN_BITS'(1);
          ovf_d  = 1'b0;
          win_d  = WIN_BITS'(char_i);
        end
      end
      // Advance the line on every newline
      if (is_nl) begin
        if (row_q != ROW_MAX) row_d = row_q + ROW_BITS'(1);
        col_d = '0;
      end
    end
  end

  // Token descriptors
  always_comb begin
    flush_desc.kind = (mode_q == MODE_IDENT)  ? TK_IDENT :
                      (mode_q == MODE_NUMBER) ? TK_NUMBER : TK_OPER;
    flush_desc.win  = win_q;
    flush_desc.row  = row_q;
    flush_desc.col  = tcol_q;
    flush_desc.len  = (mode_q == MODE_SLASH) ? LEN_BITS'(1) : len_q;
    flush_desc.too  = (mode_q == MODE_SLASH) ? 1'b0 : ovf_q;

    idle_desc.kind  = is_delim ? TK_DELIM : TK_OPER;
    idle_desc.win   = '0;
    idle_desc.row   = row_q;
    idle_desc.col   = col_inc;
    idle_desc.len   = LEN_BITS'(1);
    idle_desc.too   = 1'b0;

    end_desc.kind   = TK_END;
    end_desc.win    = '0;
    end_desc.row    = row_q;
    end_desc.col    = col_end;
    end_desc.len    = '0;
    end_desc.too    = 1'b0;
  end

  // Queue entry for this byte
  always_comb begin
    push_o      = 1'b0;
    entry_o.two = 1'b0;
    entry_o.d0  = flush_desc;
    entry_o.d1  = end_desc;
    if (accept && eoi_i) begin
      push_o = 1'b1;
      if (pend_tok) begin
        entry_o.two = 1'b1;
      end else begin
        entry_o.d0 = end_desc;
      end
    end else if (byte_step) begin
      push_o = flush_step || idle_tok;
      if (flush_step && idle_tok) begin
        entry_o.two = 1'b1;
        entry_o.d1  = idle_desc;
      end else if (idle_tok) begin
        entry_o.d0 = idle_desc;
      end
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      win_q  <= '0;
      len_q  <= '0;
      row_q  <= ROW_BITS'(1);
      col_q  <= '0;
      tcol_q <= '0;
      ovf_q  <= 1'b0;
    end else begin
      mode_q <= mode_d;
      win_q  <= win_d;
      len_q  <= len_d;
      row_q  <= row_d;
      col_q  <= col_d;
      tcol_q <= tcol_d;
      ovf_q  <= ovf_d;
    end
  end

endmodule

// ----- rtl/clx_queue.sv -----
// Short queue of token entries between the lexer front and back.
// Register based, one push and one pop per cycle. Depends on clx_pkg.
module clx_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  clx_pkg::clx_entry_t   entry_i,
  input  logic                  pop_i,
  output clx_pkg::clx_entry_t   head_o,
  output logic                  empty_o,
  output logic                  full_o
);
  import clx_pkg::*;

  clx_entry_t          slots_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]   cnt_q, cnt_d;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign head_o  = slots_q[rd_ptr_q];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the pushed entry
  always_ff @(posedge clk_i) begin
    if (push_i) slots_q[wr_ptr_q] <= entry_i;
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i))
    else $error("clx_queue: push into full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("clx_queue: pop from empty queue");

endmodule

// ----- rtl/clx_back.sv -----
// Lexer back end: takes queued entries, resolves keywords and hands tokens
// out one per cycle when ready via an output register. Depends on clx_pkg.
module clx_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  clx_pkg::clx_entry_t           head_i,
  input  logic                          empty_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [clx_pkg::OUT_DATA_W-1:0] out_data_o,
  output logic                          out_last_o
);
  import clx_pkg::*;

  logic                   valid_q, valid_d;
  logic                   sel_q, sel_d;
  token_kind_e            kind_q, kind_d;
  logic [KW_W-1:0]        kw_q, kw_d;
  logic [ROW_BITS-1:0]    row_q;
  logic [COL_BITS-1:0]    col_q;
  logic [TOK_LEN_W-1:0]   len_q;
  logic                   too_q;
  logic                   last_q, last_d;

  logic                   load;
  clx_desc_t              desc;
  kw_match_t              kw_hit;

  // Pick the next token of the head entry
  assign load   = !empty_i && (!valid_q || out_ready_i);
  assign desc   = sel_q ? head_i.d1 : head_i.d0;
  assign last_d = sel_q || !head_i.two;
  assign pop_o  = load && last_d;
  assign kw_hit = kw_lookup(desc.win, desc.len, desc.too);

  // Resolve keywords
  always_comb begin
    kind_d = desc.kind;
    kw_d   = '0;
    if (desc.kind == TK_IDENT && kw_hit.hit) begin
      kind_d = TK_KEYWORD;
      kw_d   = kw_hit.idx;
    end
  end

  // Hold the output until taken, step to the second token of an entry
  always_comb begin
    valid_d = valid_q;
    sel_d   = sel_q;
    if (load) begin
      valid_d = 1'b1;
      sel_d   = !last_d;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sel_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      sel_q   <= sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= kind_d;
      kw_q   <= kw_d;
      row_q  <= desc.row;
      col_q  <= desc.col;
      len_q  <= TOK_LEN_W'(desc.len);
      too_q  <= desc.too;
      last_q <= last_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_last_o  = last_q;
  assign out_data_o  = OUT_DATA_W'({too_q, len_q, col_q, row_q, kw_q, kind_q});

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && kind_q == TK_END) |-> last_q)
    else $error("clx_back: end token not marked last");

  a_kw_only_keyword: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && kind_q != TK_KEYWORD) |-> (kw_q == '0))
    else $error("clx_back: keyword index on non-keyword token");

  a_keyword_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && kind_q == TK_KEYWORD) |-> (!too_q && kw_q < KW_W'(NUM_KW)))
    else $error("clx_back: bad keyword token");

  a_second_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sel_q |-> !empty_i)
    else $error("clx_back: entry left before its second token");

endmodule

// ----- test/clx_token_check.sv -----
`timescale 1ns / 1ps
// Token checker for the C subset lexer: keyword spellings shared with the stimulus,
// a byte-by-byte token predictor and the comparison of every output descriptor.
// Depends on clx_pkg for the token kinds, lexer modes and field widths.
package lex_tb_pkg;

  // Keyword spellings in index order
  function automatic string keyword_text(int i);
    case (i)
      0: return "int";
      1: return "float";
      2: return "char";
      3: return "double";
      4: return "void";
      5: return "if";
      6: return "else";
      7: return "while";
      8: return "for";
      default: return "return";
    endcase
  endfunction

endpackage

module clx_token_check
  import clx_pkg::*;
  import lex_tb_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_tvalid_i,
  input  logic                  s_tready_i,
  input  logic [CHAR_W-1:0]     s_tdata_i,
  input  logic                  s_tlast_i,
  input  logic                  m_tvalid_i,
  input  logic                  m_tready_i,
  input  logic [OUT_DATA_W-1:0] m_tdata_i,
  input  logic                  m_tlast_i,
  output int                    fail_count_o,
  output int                    pending_o,
  output int                    checked_o,
  output int                    overlong_o,
  output int                    pair_steps_o,
  output logic [5:0]            kinds_seen_o
);

  localparam int WORD_MAX = MAX_TOKEN_LEN;
  localparam int NUM_WORDS = 10;
  localparam logic [ROW_BITS-1:0] ROW_TOP = '1;
  localparam logic [COL_BITS-1:0] COL_TOP = '1;

  localparam logic [7:0] C_NEWLINE = 8'h0A;
  localparam logic [7:0] C_QUOTE   = 8'h22;
  localparam logic [7:0] C_HASH    = 8'h23;
  localparam logic [7:0] C_STAR    = 8'h2A;
  localparam logic [7:0] C_SLASH   = 8'h2F;

  // Bit positions of the descriptor fields in tdata
  localparam int AT_KW  = KIND_W;
  localparam int AT_ROW = AT_KW + KW_W;
  localparam int AT_COL = AT_ROW + ROW_BITS;
  localparam int AT_LEN = AT_COL + COL_BITS;
  localparam int AT_TOO = AT_LEN + TOK_LEN_W;

  typedef struct packed {
    token_kind_e           kind;
    logic [KW_W-1:0]       kw;
    logic [ROW_BITS-1:0]   row;
    logic [COL_BITS-1:0]   col;
    logic [TOK_LEN_W-1:0]  len;
    logic                  too;
    logic                  last;
  } lex_token_t;

  // Tokens predicted but not yet seen on the output
  lex_token_t token_q[$];

  // Predicted scanner state
  lex_mode_e            mode;
  logic [47:0]          word_win;
  int                   word_len;
  bit                   word_over;
  logic [ROW_BITS-1:0]  cur_row;
  logic [COL_BITS-1:0]  cur_col;
  logic [COL_BITS-1:0]  tok_col;
  int                   step_count;

  function automatic bit is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_oper(logic [7:0] c);
    return c == "+" || c == "-" || c == "*" || c == "/" || c == "=" || c == "<" || c == ">";
  endfunction

  function automatic bit is_delim(logic [7:0] c);
    return c == ";" || c == "," || c == "(" || c == ")" || c == "{" || c == "}";
  endfunction

  // Right-aligned byte code of a spelling, as the word window holds it
  function automatic logic [47:0] keyword_code(string s);
    logic [47:0] code;
    code = '0;
    for (int i = 0; i < s.len(); i++) code = {code[39:0], s[i]};
    return code;
  endfunction

  task automatic clear_state();
    mode      = MODE_IDLE;
    word_win  = '0;
    word_len  = 0;
    word_over = 1'b0;
    cur_row   = ROW_BITS'(1);
    cur_col   = '0;
    tok_col   = '0;
  endtask

  task automatic push_token(token_kind_e kind, int kw, logic [ROW_BITS-1:0] row,
                            logic [COL_BITS-1:0] col, int len, bit too);
    lex_token_t t;
    t.kind = kind;
    t.kw   = kw[KW_W-1:0];
    t.row  = row;
    t.col  = col;
    t.len  = len[TOK_LEN_W-1:0];
    t.too  = too;
    t.last = 1'b0;
    token_q.push_back(t);
    step_count++;
  endtask

  task automatic start_word(lex_mode_e m, logic [7:0] c);
    mode      = m;
    tok_col   = cur_col;
    word_len  = 1;
    word_over = 1'b0;
    word_win  = {40'b0, c};
  endtask

  // Extend the pending word; beyond the limit only note the overflow
  task automatic grow_word(logic [7:0] c);
    if (word_len < WORD_MAX) begin
      if (word_len < 6) word_win = {word_win[39:0], c};
      word_len++;
    end else begin
      word_over = 1'b1;
    end
  endtask

  // Emit the pending word or lone slash and drop back to idle
  task automatic close_word();
    token_kind_e kind;
    int          idx;
    string       s;
    kind = TK_IDENT;
    idx  = 0;
    case (mode)
      MODE_IDENT: begin
        if (!word_over) begin
          for (int i = NUM_WORDS - 1; i >= 0; i--) begin
            s = keyword_text(i);
            if (word_len == s.len() && word_win == keyword_code(s)) begin
              kind = TK_KEYWORD;
              idx  = i;
            end
          end
        end
        push_token(kind, idx, cur_row, tok_col, word_len, word_over);
      end
      MODE_NUMBER: push_token(TK_NUMBER, 0, cur_row, tok_col, word_len, word_over);
      MODE_SLASH:  push_token(TK_OPER, 0, cur_row, tok_col, 1, 1'b0);
      default: ;
    endcase
    mode      = MODE_IDLE;
    word_len  = 0;
    word_over = 1'b0;
    word_win  = '0;
  endtask

  // Treat a byte as seen from the idle state
  task automatic idle_byte(logic [7:0] c);
    if (c == C_HASH) begin
      mode = MODE_DIRECTIVE;
    end else if (c == C_SLASH) begin
      mode    = MODE_SLASH;
      tok_col = cur_col;
    end else if (c == C_QUOTE) begin
      mode = MODE_STRING;
    end else if (is_letter(c)) begin
      start_word(MODE_IDENT, c);
    end else if (is_digit(c)) begin
      start_word(MODE_NUMBER, c);
    end else if (is_oper(c)) begin
      push_token(TK_OPER, 0, cur_row, cur_col, 1, 1'b0);
    end else if (is_delim(c)) begin
      push_token(TK_DELIM, 0, cur_row, cur_col, 1, 1'b0);
    end
  endtask

  // Predict the tokens caused by one accepted request
  task automatic scan_byte(logic [7:0] c, logic eoi);
    bit                   to_idle;
    logic [COL_BITS-1:0]  end_col;
    lex_token_t           t;
    to_idle    = 1'b0;
    step_count = 0;
    if (eoi) begin
      end_col = (cur_col == COL_TOP) ? cur_col : cur_col + 1'b1;
      close_word();
      push_token(TK_END, 0, cur_row, end_col, 0, 1'b0);
      clear_state();
    end else begin
      if (c != C_NEWLINE && cur_col != COL_TOP) cur_col++;
      case (mode)
        MODE_IDENT: begin
          if (is_letter(c) || is_digit(c)) grow_word(c);
          else begin
            close_word();
            to_idle = 1'b1;
          end
        end
        MODE_NUMBER: begin
          if (is_digit(c)) grow_word(c);
          else begin
            close_word();
            to_idle = 1'b1;
          end
        end
        MODE_SLASH: begin
          if (c == C_SLASH) mode = MODE_LINE;
          else if (c == C_STAR) mode = MODE_BLOCK;
          else begin
            close_word();
            to_idle = 1'b1;
          end
        end
        MODE_DIRECTIVE, MODE_LINE: begin
          if (c == C_NEWLINE) mode = MODE_IDLE;
        end
        MODE_BLOCK: begin
          if (c == C_STAR) mode = MODE_BLOCK_STAR;
        end
        MODE_BLOCK_STAR: begin
          if (c == C_SLASH) mode = MODE_IDLE;
          else if (c != C_STAR) mode = MODE_BLOCK;
        end
        MODE_STRING: begin
          if (c == C_QUOTE) mode = MODE_IDLE;
        end
        default: begin
          mode    = MODE_IDLE;
          to_idle = 1'b1;
        end
      endcase
      if (to_idle) idle_byte(c);
      if (c == C_NEWLINE) begin
        if (cur_row != ROW_TOP) cur_row++;
        cur_col = '0;
      end
    end
    // Mark the final token of this request
    if (step_count > 0) begin
      t = token_q.pop_back();
      t.last = 1'b1;
      token_q.push_back(t);
    end
    if (step_count > 1) pair_steps_o++;
  endtask

  // Print one mismatch line (the first few only) and count it
  task automatic report(string what, longint got, longint want);
    fail_count_o++;
    if (fail_count_o <= 40)
      $display("[%0t] token %0d: %s is %0d, predicted %0d", $time, checked_o, what, got, want);
  endtask

  // Compare one output descriptor with the oldest prediction
  task automatic check_token();
    lex_token_t want;
    if (token_q.size() == 0) begin
      report("unpredicted token, kind", m_tdata_i[KIND_W-1:0], -1);
      return;
    end
    want = token_q.pop_front();
    if (m_tdata_i[KIND_W-1:0] !== want.kind)
      report("token_kind", m_tdata_i[KIND_W-1:0], want.kind);
    if (m_tdata_i[AT_KW +: KW_W] !== want.kw)
      report("keyword_index", m_tdata_i[AT_KW +: KW_W], want.kw);
    if (m_tdata_i[AT_ROW +: ROW_BITS] !== want.row)
      report("start_row", m_tdata_i[AT_ROW +: ROW_BITS], want.row);
    if (m_tdata_i[AT_COL +: COL_BITS] !== want.col)
      report("start_column", m_tdata_i[AT_COL +: COL_BITS], want.col);
    if (m_tdata_i[AT_LEN +: TOK_LEN_W] !== want.len)
      report("token_length", m_tdata_i[AT_LEN +: TOK_LEN_W], want.len);
    if (m_tdata_i[AT_TOO] !== want.too)
      report("too_long", m_tdata_i[AT_TOO], want.too);
    if (m_tlast_i !== want.last)
      report("last_of_run", m_tlast_i, want.last);
    kinds_seen_o[want.kind] = 1'b1;
    if (want.too) overlong_o++;
    checked_o++;
  endtask

  // Predict on each input request, then check each output request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_state();
      token_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
      checked_o    = 0;
      overlong_o   = 0;
      pair_steps_o = 0;
      kinds_seen_o = '0;
    end else begin
      if (s_tvalid_i && s_tready_i) scan_byte(s_tdata_i, s_tlast_i);
      if (m_tvalid_i && m_tready_i) check_token();
      pending_o = token_q.size();
    end
  end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// Top of the C subset lexer testbench: clock, reset, source byte stimulus and verdict.
// Depends on clx_pkg, c_subset_lexer and clx_token_check (with lex_tb_pkg).
module tb_top;
  import clx_pkg::*;
  import lex_tb_pkg::*;

  localparam int RANDOM_ITEMS = 1450;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 32;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  s_axis_tlast;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;

  int         fail_count;
  int         pending_count;
  int         checked_count;
  int         overlong_count;
  int         pair_count;
  logic [5:0] kinds_seen;

  int n_bytes;
  int n_ends;
  bit steady;
  bit hold_req;

  c_subset_lexer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  clx_token_check u_token_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tlast_i    (s_axis_tlast),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .m_tlast_i    (m_axis_tlast),
    .fail_count_o (fail_count),
    .pending_o    (pending_count),
    .checked_o    (checked_count),
    .overlong_o   (overlong_count),
    .pair_steps_o (pair_count),
    .kinds_seen_o (kinds_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Give up on a hung run
  initial begin
    #8_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Output side: stall before each request, hold off for long once when asked
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 4);
      if (hold_req) begin
        stall    = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      @(negedge clk_i);
    end
  end

  // Offer one request after a random gap and hold it until taken
  task automatic put_byte(logic [7:0] c, bit eoi);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= eoi;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    if (eoi) n_ends++;
    else n_bytes++;
  endtask

  task automatic put_str(string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i], 1'b0);
  endtask

  // End of source; the next file may run without gaps
  task automatic put_end();
    put_byte(8'($urandom), 1'b1);
    steady = ($urandom_range(0, 3) == 0);
  endtask

  function automatic logic [7:0] word_char(bit head);
    int r;
    r = $urandom_range(0, head ? 52 : 62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r == 52) return "_";
    return 8'("0" + r - 53);
  endfunction

  // Word or number, now and then past the length limit
  task automatic put_word(bit digits);
    int len;
    len = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 8);
    for (int i = 0; i < len; i++)
      put_byte(digits ? 8'("0" + $urandom_range(0, 9)) : word_char(i == 0), 1'b0);
  endtask

  // Random bytes up to, not including, a terminator
  task automatic put_body(logic [7:0] stop, logic [7:0] swap);
    logic [7:0] b;
    repeat ($urandom_range(0, 10)) begin
      b = 8'($urandom_range(0, 255));
      put_byte((b == stop) ? swap : b, 1'b0);
    end
  endtask

  // One piece of C-like source, then often a separator
  task automatic put_fragment();
    int         pick;
    string      w;
    logic [7:0] b;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      put_word(1'b0);
    end else if (pick < 32) begin
      w = keyword_text($urandom_range(0, 9));
      case ($urandom_range(0, 5))
        0: w = {w, "x"};
        1: w = w.substr(0, w.len() - 2);
        default: ;
      endcase
      put_str(w);
    end else if (pick < 42) begin
      put_word(1'b1);
    end else if (pick < 52) begin
      w = "+-*/=<>";
      put_byte(w[$urandom_range(0, 6)], 1'b0);
    end else if (pick < 62) begin
      w = ";,(){}";
      put_byte(w[$urandom_range(0, 5)], 1'b0);
    end else if (pick < 70) begin
      put_byte(($urandom_range(0, 1) == 0) ? 8'h0A : 8'h09, 1'b0);
    end else if (pick < 75) begin
      put_str("#");
      put_body(8'h0A, " ");
      put_byte(8'h0A, 1'b0);
    end else if (pick < 80) begin
      put_str("//");
      put_body(8'h0A, " ");
      put_byte(8'h0A, 1'b0);
    end else if (pick < 86) begin
      // Block comment with stars, slashes and newlines inside, closed by a star run
      put_str("/*");
      repeat ($urandom_range(0, 12)) begin
        case ($urandom_range(0, 7))
          0, 1: b = "*";
          2: b = "/";
          3: b = 8'h0A;
          4: b = " ";
          default: b = word_char(1'b0);
        endcase
        put_byte(b, 1'b0);
      end
      repeat ($urandom_range(1, 3)) put_byte("*", 1'b0);
      put_byte("/", 1'b0);
    end else if (pick < 90) begin
      put_byte(8'h22, 1'b0);
      put_body(8'h22, "x");
      put_byte(8'h22, 1'b0);
    end else if (pick < 94) begin
      // Lone slash, ended by whatever follows
      put_byte("/", 1'b0);
      case ($urandom_range(0, 4))
        0: put_word(1'b0);
        1: put_word(1'b1);
        2: put_byte(" ", 1'b0);
        3: put_byte(";", 1'b0);
        default: put_byte(8'h0A, 1'b0);
      endcase
    end else if (pick < 98) begin
      put_byte(8'($urandom_range(0, 255)), 1'b0);
    end else begin
      // End of source, often inside something still open
      case ($urandom_range(0, 6))
        0: put_str("/*");
        1: put_str("//");
        2: put_byte(8'h22, 1'b0);
        3: put_str("#");
        4: put_str("/");
        5: put_word(1'($urandom_range(0, 1)));
        default: ;
      endcase
      put_end();
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3: put_byte(" ", 1'b0);
      7: put_byte(8'h0A, 1'b0);
      8: put_byte(8'h09, 1'b0);
      9: put_str("  ");
      default: ;
    endcase
  endtask

  initial begin
    int base;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    steady        = 1'b0;
    hold_req      = 1'b0;
    n_bytes       = 0;
    n_ends        = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: directive, keyword, lone slash, comments, string, pending number at end
    put_str("#x\nint a/b;//c\n/***/\"s\"+9");
    put_end();

    // Fill the block while the output side holds off
    steady   = 1'b1;
    hold_req = 1'b1;
    for (int i = 0; i < 12; i++) put_str({string'(8'("a" + i)), ";"});
    put_end();

    // Random source text split into files by end markers
    base = n_bytes + n_ends;
    while (n_bytes + n_ends - base < RANDOM_ITEMS) put_fragment();
    put_end();

    s_axis_tvalid <= 1'b0;
    wait (pending_count == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d source bytes in %0d files, with random gaps and one long output hold.",
             n_bytes, n_ends);
    $display("Checked %0d tokens, kinds seen %b, %0d overlong, %0d bytes with two tokens.",
             checked_count, kinds_seen, overlong_count, pair_count);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/clx_pkg.sv
rtl/clx_front.sv
rtl/clx_queue.sv
rtl/clx_back.sv
rtl/c_subset_lexer.sv
test/clx_token_check.sv
test/tb_top.sv
